// File: design/abkf_pkg.sv
// Shared types and constants for the angle and bias Kalman filter.
`timescale 1ns / 1ps
package abkf_pkg;

    localparam int DATA_W  = 32;
    localparam int NOISE_W = 24;
    localparam int DT_W    = 20;
    localparam int IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 24'd1049;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 24'd3146;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd31457;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL
    } alu_op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALU,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > 64'sh7FFFFFFF)
            begin
                r = 32'sh7FFFFFFF;
            end
            else if (v < -64'sh80000000)
            begin
                r = 32'sh80000000;
            end
            else
            begin
                r = v[DATA_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// File: design/abkf_alu.sv
// Shared saturating add, subtract and rounding fixed-point multiply unit.
`timescale 1ns / 1ps
module abkf_alu #(
    parameter int FRAC_BITS = 20
) (
    input  logic                             clk,
    input  abkf_pkg::alu_op_t                op,
    input  logic signed [abkf_pkg::DATA_W-1:0] a,
    input  logic signed [abkf_pkg::DATA_W-1:0] b,
    output logic signed [abkf_pkg::DATA_W-1:0] res
);
    import abkf_pkg::*;

    logic signed [63:0]       prod;
    logic signed [63:0]       rnd;
    logic signed [DATA_W-1:0] res_next;
    logic signed [DATA_W-1:0] res_reg;

    // One operation per cycle, result registered.
    always_comb
    begin
        prod = 64'(a) * 64'(b);
        rnd  = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        case (op)
            OP_ADD:  res_next = sat32(64'(a) + 64'(b));
            OP_SUB:  res_next = sat32(64'(a) - 64'(b));
            OP_MUL:  res_next = sat32(rnd);
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: design/abkf_div.sv
// Restoring divider for the gains: (num * 2^FRAC_BITS) / den, saturated.
`timescale 1ns / 1ps
module abkf_div #(
    parameter int FRAC_BITS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [abkf_pkg::DATA_W-1:0] num,
    input  logic [abkf_pkg::DATA_W:0]          den,
    output logic                               busy,
    output logic signed [abkf_pkg::DATA_W-1:0] quo
);
    import abkf_pkg::*;

    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]      dvd_reg, dvd_next;
    logic [DATA_W+1:0]  rem_reg, rem_next;
    logic [DATA_W:0]    den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [DATA_W+1:0]  trial;
    logic [DATA_W+1:0]  diff;
    logic [NW:0]        mag;
    logic signed [63:0] sq;

    // One quotient bit per cycle on the magnitude.
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[DATA_W:0], dvd_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        if (start)
        begin
            neg_next  = num[DATA_W-1];
            dvd_next  = {(num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num)), FRAC_BITS'(0)};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_next = diff;
            end
            else
            begin
                rem_next = trial;
            end
            dvd_next = {dvd_reg[NW-2:0], ~diff[DATA_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Sign and saturate the quotient magnitude.
    always_comb
    begin
        mag = {1'b0, dvd_reg};
        sq  = neg_reg ? -64'(mag) : 64'(mag);
        quo = sat32(sq);
    end

    assign busy = busy_reg;

endmodule

// File: design/angle_bias_kalman_filter.sv
// Top level: sequencer and state of the two-state angle and gyro bias Kalman filter.
//
//  Channel | Signals                                       | Direction
//  in      | in_valid, in_ready, measured_angle, gyro_rate, time_step | sink
//  out     | out_valid, out_ready, filtered_angle, bias_estimate      | source
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data                | sink
//
// Each sample runs the predict steps, two gain divider passes, then the correct steps:
// 27 ALU steps in all, each with an issue and a write-back phase, and a finishing step.
// With a non-positive innovation variance the divider is skipped and the gains are zero.
// in_ready is high only while idle, so no new sample is accepted until the last is done.
// Reset restores the noise registers and state to their initial values.
// A stalled result beat holds in the output register until it is taken; a following
// sample is still accepted and held at its last step until the register is free.
`timescale 1ns / 1ps
module angle_bias_kalman_filter #(
    parameter int FRAC_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [abkf_pkg::DATA_W-1:0]  measured_angle,
    input  logic signed [abkf_pkg::DATA_W-1:0]  gyro_rate,
    input  logic [abkf_pkg::DT_W-1:0]           time_step,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [abkf_pkg::DATA_W-1:0]  filtered_angle,
    output logic signed [abkf_pkg::DATA_W-1:0]  bias_estimate,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abkf_pkg::IDX_W-1:0]          cfg_index,
    input  logic [abkf_pkg::NOISE_W-1:0]        cfg_data
);
    import abkf_pkg::*;

    localparam logic signed [DATA_W-1:0] UNITY_Q = DATA_W'(1) <<< FRAC_BITS;

    // Register file slots used by the microcode.
    localparam int NR = 16;
    typedef enum logic [3:0] {
        R_AE, R_BE, R_PAA, R_PAB, R_PBA, R_PBB, R_MEAS, R_DT,
        R_T, R_U, R_K0, R_K1, R_Y, R_P00, R_P01, R_RATE
    } reg_id_t;

    typedef struct packed {
        alu_op_t op;
        reg_id_t a;
        logic    a_cst; // a operand is a noise constant
        logic [IDX_W-1:0] cst;
        reg_id_t b;
        reg_id_t d;
    } uop_t;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_GAIN = 5'd13;
    localparam logic [PC_W-1:0] PC_LAST = 5'd26;

    function automatic uop_t mk(alu_op_t op, reg_id_t a, reg_id_t b, reg_id_t d);
        uop_t u;
        begin
            u = '{op: op, a: a, a_cst: 1'b0, cst: REG_ANGLE_NOISE, b: b, d: d};
            return u;
        end
    endfunction

    // Microcode: predict (0..13), gain by divider between, correct (14..26).
    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        begin
            case (pc)
                5'd0:  u = mk(OP_SUB, R_RATE, R_BE, R_RATE);
                5'd1:  u = mk(OP_MUL, R_DT, R_RATE, R_T);
                5'd2:  u = mk(OP_ADD, R_AE, R_T, R_AE);
                5'd3:  u = mk(OP_MUL, R_DT, R_PBB, R_T);
                5'd4:  u = mk(OP_SUB, R_T, R_PAB, R_T);
                5'd5:  u = mk(OP_SUB, R_T, R_PBA, R_T);
                5'd6:  u = '{op: OP_ADD, a: R_T, a_cst: 1'b1, cst: REG_ANGLE_NOISE,
                             b: R_T, d: R_T};
                5'd7:  u = mk(OP_MUL, R_DT, R_T, R_T);
                5'd8:  u = mk(OP_ADD, R_PAA, R_T, R_PAA);
                5'd9:  u = mk(OP_MUL, R_DT, R_PBB, R_U);
                5'd10: u = mk(OP_SUB, R_PAB, R_U, R_PAB);
                5'd11: u = mk(OP_SUB, R_PBA, R_U, R_PBA);
                5'd12: u = '{op: OP_MUL, a: R_T, a_cst: 1'b1, cst: REG_BIAS_NOISE,
                             b: R_DT, d: R_U};
                5'd13: u = mk(OP_ADD, R_PBB, R_U, R_PBB);
                5'd14: u = mk(OP_SUB, R_MEAS, R_AE, R_Y);
                5'd15: u = mk(OP_MUL, R_K0, R_Y, R_T);
                5'd16: u = mk(OP_ADD, R_AE, R_T, R_AE);
                5'd17: u = mk(OP_MUL, R_K1, R_Y, R_T);
                5'd18: u = mk(OP_ADD, R_BE, R_T, R_BE);
                5'd19: u = mk(OP_MUL, R_K0, R_P00, R_T);
                5'd20: u = mk(OP_SUB, R_PAA, R_T, R_PAA);
                5'd21: u = mk(OP_MUL, R_K0, R_P01, R_T);
                5'd22: u = mk(OP_SUB, R_PAB, R_T, R_PAB);
                5'd23: u = mk(OP_MUL, R_K1, R_P00, R_T);
                5'd24: u = mk(OP_SUB, R_PBA, R_T, R_PBA);
                5'd25: u = mk(OP_MUL, R_K1, R_P01, R_T);
                default: u = mk(OP_SUB, R_PBB, R_T, R_PBB);
            endcase
            return u;
        end
    endfunction

    seq_state_t state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            ph_reg, ph_next;   // 0: issue, 1: write back
    logic            dsel_reg, dsel_next; // divider pass: 0 -> K0, 1 -> K1
    logic            dstart;
    logic signed [DATA_W-1:0] rf_reg [NR];
    logic [NOISE_W-1:0] an_reg, bn_reg, mn_reg;
    logic signed [DATA_W-1:0] fa_reg, be_reg;
    logic            ov_reg;
    uop_t            u;
    logic signed [DATA_W-1:0] opa, opb, alu_res, quo;
    logic            dbusy;
    logic [DATA_W:0] s_sum;
    logic            s_pos;
    logic            acc;
    logic            ld_out;

    assign acc       = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = ov_reg;
    assign filtered_angle = fa_reg;
    assign bias_estimate  = be_reg;

    // The finished estimates move to the output register once it is free.
    assign ld_out = (state_reg == ST_DONE) && (!ov_reg || out_ready);

    // Innovation variance, 33 bits, positive check.
    assign s_sum = {rf_reg[R_PAA][DATA_W-1], rf_reg[R_PAA]} + {9'd0, mn_reg};
    assign s_pos = !s_sum[DATA_W] && (s_sum != '0);

    // Operand selection for the shared unit.
    always_comb
    begin
        u   = ucode(pc_reg);
        opa = rf_reg[u.a];
        if (u.a_cst)
        begin
            opa = (u.cst == REG_ANGLE_NOISE) ? DATA_W'({8'd0, an_reg})
                                             : DATA_W'({8'd0, bn_reg});
        end
        opb = rf_reg[u.b];
    end

    abkf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .clk (clk), .op (u.op), .a (opa), .b (opb), .res (alu_res)
    );

    abkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk (clk), .rst_n (rst_n), .start (dstart),
        .num (dsel_reg ? rf_reg[R_PBA] : rf_reg[R_PAA]),
        .den (s_sum), .busy (dbusy), .quo (quo)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ph_next    = ph_reg;
        dsel_next  = dsel_reg;
        dstart     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    state_next = ST_ALU;
                    pc_next    = '0;
                    ph_next    = 1'b0;
                end
            end
            ST_ALU:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (pc_reg == PC_GAIN)
                    begin
                        state_next = ST_DIV;
                        dsel_next  = 1'b0;
                        ph_next    = 1'b0;
                    end
                    else if (pc_reg == PC_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                if (!s_pos)
                begin
                    state_next = ST_ALU;
                end
                else if (!ph_reg)
                begin
                    dstart  = 1'b1;
                    ph_next = 1'b1;
                end
                else if (!dbusy && !dstart)
                begin
                    ph_next = 1'b0;
                    if (dsel_reg)
                    begin
                        state_next = ST_ALU;
                    end
                    dsel_next = !dsel_reg;
                end
            end
            ST_DONE:
            begin
                if (ld_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers, state and noise registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            ph_reg    <= 1'b0;
            dsel_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            an_reg    <= ANGLE_NOISE_RST;
            bn_reg    <= BIAS_NOISE_RST;
            mn_reg    <= MEASURE_NOISE_RST;
            for (int i = 0; i < NR; i++)
            begin
                rf_reg[i] <= ((i == int'(R_PAA)) || (i == int'(R_PBB))) ? UNITY_Q : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ph_reg    <= ph_next;
            dsel_reg  <= dsel_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ANGLE_NOISE:   an_reg <= cfg_data;
                    REG_BIAS_NOISE:    bn_reg <= cfg_data;
                    REG_MEASURE_NOISE: mn_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (acc)
            begin
                rf_reg[R_MEAS] <= measured_angle;
                rf_reg[R_RATE] <= gyro_rate;
                rf_reg[R_DT]   <= DATA_W'({12'd0, time_step});
            end
            if (state_reg == ST_ALU && ph_reg)
            begin
                rf_reg[u.d] <= alu_res;
            end
            if (state_reg == ST_DIV)
            begin
                if (!s_pos)
                begin
                    rf_reg[R_K0] <= '0;
                    rf_reg[R_K1] <= '0;
                end
                else if (ph_reg && !dbusy)
                begin
                    if (dsel_reg)
                    begin
                        rf_reg[R_K1] <= quo;
                    end
                    else
                    begin
                        rf_reg[R_K0] <= quo;
                    end
                end
                rf_reg[R_P00] <= rf_reg[R_PAA];
                rf_reg[R_P01] <= rf_reg[R_PAB];
            end
            if (ld_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Output register loads the final estimates.
    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            fa_reg <= rf_reg[R_AE];
            be_reg <= rf_reg[R_BE];
        end
    end

endmodule
